>>> rtl/wcc_pkg.sv
// Package for the window correlation block: default parameters, state and
// operation codes, and the command and status structs between controller and datapath.
// No dependencies.
package wcc_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int MAX_PAIRS_DEF     = 4096;
    localparam int FRACTION_BITS_DEF = 15;

    // Step counter width; holds twice the largest fraction width.
    localparam int STEP_BITS = 5;

    typedef enum logic [2:0] {
        S_ACC,
        S_LOAD,
        S_RUN,
        S_SAVE,
        S_CHK,
        S_DIV,
        S_SQRT,
        S_OUT
    } t_state;

    // Products formed by the shared shift-add multiplier, in issue order.
    typedef enum logic [2:0] {
        OP_N_SAB,
        OP_SA_SB,
        OP_N_SAA,
        OP_SA_SA,
        OP_N_SBB,
        OP_SB_SB,
        OP_DEN,
        OP_MAG_SQ
    } t_mul_op;

    typedef struct packed {
        logic                 acc_en;
        logic                 clear;
        logic                 load;
        logic                 save;
        logic                 chk;
        logic                 div_step;
        logic                 sqrt_step;
        t_mul_op              op;
        logic [STEP_BITS-1:0] bit_idx;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic flat;
    } t_status;

endpackage

>>> rtl/window_correlation_coefficient.sv
// After a last pair, six products go through a bit-serial shift-add multiplier
// (one multiplier bit per cycle, stopping at the top set bit); unless the window is
// flat, den and mag^2 follow, then a 2F+1-bit restoring divide and an F+1-bit root.
// Throughput: one pair per cycle while a window accumulates; input is stalled
// from the last pair until the result transaction completes.
// Reset: synchronous active low; clears all sums and returns to accumulation.
module window_correlation_coefficient
    import wcc_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int MAX_PAIRS     = MAX_PAIRS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_sample_a,
    input  logic [15:0] i_sample_b,
    input  logic        i_last_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_correlation,
    output logic        o_flat_window
);

    t_cmd    cmd;
    t_status status;

    wcc_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_sample(i_last_sample),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    wcc_datapath #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_PAIRS    (MAX_PAIRS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_a   (i_sample_a),
        .i_sample_b   (i_sample_b),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_correlation(o_correlation),
        .o_flat_window(o_flat_window)
    );

`ifndef SYNTHESIS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result is pending");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_correlation)
                                  && $stable(o_flat_window)))
        else $error("stalled result changed");
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_sample) |=> o_stall)
        else $error("input not stalled after last pair");
`endif

endmodule

>>> rtl/wcc_ctrl.sv
// Controller state machine of the window correlation block.
// Depends on wcc_pkg for the state, operation, command and status types.
module wcc_ctrl
    import wcc_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last_sample,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state               r_state, n_state;
    t_mul_op              r_op, n_op;
    logic [STEP_BITS-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_op    <= OP_N_SAB;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.op      = r_op;
        o_cmd.bit_idx = r_cnt;
        o_stall = (r_state != S_ACC);
        o_valid = (r_state == S_OUT);
        unique case (r_state)
            S_ACC: begin
                o_cmd.acc_en = i_valid;
                if (i_valid && i_last_sample) begin
                    n_state = S_LOAD;
                    n_op    = OP_N_SAB;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_RUN;
            end
            S_RUN: begin
                if (!i_status.mul_busy) begin
                    n_state = S_SAVE;
                end
            end
            S_SAVE: begin
                o_cmd.save = 1'b1;
                if (r_op == OP_SB_SB) begin
                    n_state = S_CHK;
                end else if (r_op == OP_MAG_SQ) begin
                    n_state = S_DIV;
                    n_cnt   = STEP_BITS'(2 * FRACTION_BITS);
                end else begin
                    n_op    = t_mul_op'(r_op + 3'd1);
                    n_state = S_LOAD;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_status.flat) begin
                    n_state = S_OUT;
                end else begin
                    n_op    = OP_DEN;
                    n_state = S_LOAD;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_SQRT;
                    n_cnt   = STEP_BITS'(FRACTION_BITS);
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

endmodule

>>> rtl/wcc_datapath.sv
// Datapath of the window correlation block: sum accumulators, a shared
// shift-add multiplier, a restoring divider and a bit-serial square root.
// Depends on wcc_pkg for the command and status types.
module wcc_datapath
    import wcc_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int MAX_PAIRS     = MAX_PAIRS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_sample_a,
    input  logic [15:0] i_sample_b,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [15:0] o_correlation,
    output logic        o_flat_window
);

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;
    localparam int V_W   = 2 * SAMPLE_BITS + 2 * CNT_W;
    localparam int P_W   = 2 * V_W;
    localparam int QUO_W = 2 * FRACTION_BITS + 1;
    localparam int Q_W   = FRACTION_BITS + 1;
    localparam int T_W   = FRACTION_BITS + 2;

    logic [CNT_W-1:0] r_n;
    logic [SUM_W-1:0] r_sa, r_sb;
    logic [SQ_W-1:0]  r_saa, r_sbb, r_sab;

    logic [SAMPLE_BITS-1:0] a, b;
    assign a = i_sample_a[SAMPLE_BITS-1:0];
    assign b = i_sample_b[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_n   <= '0;
            r_sa  <= '0;
            r_sb  <= '0;
            r_saa <= '0;
            r_sbb <= '0;
            r_sab <= '0;
        end else if (i_cmd.acc_en && (r_n < CNT_W'(MAX_PAIRS))) begin
            r_n   <= r_n + 1'b1;
            r_sa  <= r_sa + SUM_W'(a);
            r_sb  <= r_sb + SUM_W'(b);
            r_saa <= r_saa + SQ_W'(a) * SQ_W'(a);
            r_sbb <= r_sbb + SQ_W'(b) * SQ_W'(b);
            r_sab <= r_sab + SQ_W'(a) * SQ_W'(b);
        end
    end

    // Shared multiplier; it stops as soon as the remaining multiplier bits are zero.
    logic [P_W-1:0] r_mx, r_macc;
    logic [V_W-1:0] r_my;
    logic [V_W-1:0] mul_x, mul_y;
    logic [V_W-1:0] r_p, r_mag, r_va, r_vb;
    logic           r_neg, r_flat;
    logic [P_W-1:0] r_den;
    logic [P_W:0]   r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [Q_W-1:0]   r_q;

    always_comb begin
        unique case (i_cmd.op)
            OP_N_SAB:  begin mul_x = V_W'(r_sab); mul_y = V_W'(r_n);  end
            OP_SA_SB:  begin mul_x = V_W'(r_sa);  mul_y = V_W'(r_sb); end
            OP_N_SAA:  begin mul_x = V_W'(r_saa); mul_y = V_W'(r_n);  end
            OP_SA_SA:  begin mul_x = V_W'(r_sa);  mul_y = V_W'(r_sa); end
            OP_N_SBB:  begin mul_x = V_W'(r_sbb); mul_y = V_W'(r_n);  end
            OP_SB_SB:  begin mul_x = V_W'(r_sb);  mul_y = V_W'(r_sb); end
            OP_DEN:    begin mul_x = r_va;        mul_y = r_vb;       end
            OP_MAG_SQ: begin mul_x = r_mag;       mul_y = r_mag;      end
            default:   begin mul_x = '0;          mul_y = '0;         end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my <= '0;
        end else if (i_cmd.load) begin
            r_my <= mul_y;
        end else if (r_my != '0) begin
            r_my <= r_my >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mx   <= P_W'(mul_x);
            r_macc <= '0;
        end else if (r_my != '0) begin
            if (r_my[0]) begin
                r_macc <= r_macc + r_mx;
            end
            r_mx <= r_mx << 1;
        end
    end

    logic [V_W-1:0] acc_lo;
    assign acc_lo = r_macc[V_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.save) begin
            unique case (i_cmd.op)
                OP_N_SAB, OP_N_SAA, OP_N_SBB: r_p <= acc_lo;
                OP_SA_SB: begin
                    r_neg <= (r_p < acc_lo);
                    r_mag <= (r_p < acc_lo) ? (acc_lo - r_p) : (r_p - acc_lo);
                end
                OP_SA_SA:  r_va  <= (r_p > acc_lo) ? (r_p - acc_lo) : '0;
                OP_SB_SB:  r_vb  <= (r_p > acc_lo) ? (r_p - acc_lo) : '0;
                OP_DEN:    r_den <= r_macc;
                OP_MAG_SQ: r_rem <= {1'b0, r_macc};
                default:   r_p   <= r_p;
            endcase
        end else if (i_cmd.div_step) begin
            if (r_rem >= {1'b0, r_den}) begin
                r_rem <= (r_rem - {1'b0, r_den}) << 1;
            end else begin
                r_rem <= r_rem << 1;
            end
        end
        if (i_cmd.chk) begin
            r_flat <= o_status.flat;
        end
    end

    // Quotient of mag^2 * 2^(2F) / den, then its integer square root.
    logic [T_W-1:0]   sq_t;
    logic [2*T_W-1:0] sq_tt;
    assign sq_t  = T_W'(r_q) | (T_W'(1) << i_cmd.bit_idx);
    assign sq_tt = sq_t * sq_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quo <= '0;
            r_q   <= '0;
        end else begin
            if (i_cmd.save && (i_cmd.op == OP_MAG_SQ)) begin
                r_quo <= '0;
            end else if (i_cmd.div_step) begin
                r_quo <= {r_quo[QUO_W-2:0], (r_rem >= {1'b0, r_den})};
            end
            if (i_cmd.chk) begin
                r_q <= '0;
            end else if (i_cmd.sqrt_step && (sq_tt <= (2*T_W)'(r_quo))) begin
                r_q <= sq_t[Q_W-1:0];
            end
        end
    end

    assign o_status.mul_busy = (r_my != '0);
    assign o_status.flat     = (r_va == '0) || (r_vb == '0);

    logic [16:0] q_ext, q_neg;
    assign q_ext = 17'(r_q);
    assign q_neg = 17'd0 - ((q_ext > 17'd32768) ? 17'd32768 : q_ext);

    always_comb begin
        if (r_neg) begin
            o_correlation = q_neg[15:0];
        end else if (q_ext > 17'd32767) begin
            o_correlation = 16'h7FFF;
        end else begin
            o_correlation = q_ext[15:0];
        end
    end
    assign o_flat_window = r_flat;

`ifndef SYNTHESIS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q <= Q_W'(1 << FRACTION_BITS))
        else $error("square root result above one");
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_step |-> (r_quo <= QUO_W'(1 << (2 * FRACTION_BITS))))
        else $error("quotient above one");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_my == $past(mul_y)))
        else $error("multiplier did not take its operand");
`endif

endmodule
